[rtl/s1ptw_pkg.sv]
// Shared types, constants and helper functions for the stage-1 table walker.
// Used by the front end, the command queue, the back end and the top level.
package s1ptw_pkg;

  localparam logic [63:0] HIGH_REGION_BOUND = 64'h0FF0_0000_0000_0000;
  localparam logic [2:0] LAST_LEVEL = 3'd4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] GRANULE_IDENTITY = 2'd0;
  localparam logic [1:0] GRANULE_4K = 2'd2;

  localparam logic [1:0] OUT_READ = 2'd0;
  localparam logic [1:0] OUT_DONE = 2'd1;
  localparam logic [1:0] OUT_FAULT = 2'd2;

  localparam logic [2:0] CFG_MMU_ENABLE = 3'd0;
  localparam logic [2:0] CFG_LOW_SIZE = 3'd1;
  localparam logic [2:0] CFG_LOW_GRANULE = 3'd2;
  localparam logic [2:0] CFG_HIGH_SIZE = 3'd3;
  localparam logic [2:0] CFG_HIGH_GRANULE = 3'd4;
  localparam logic [2:0] CFG_LOW_BASE = 3'd5;
  localparam logic [2:0] CFG_HIGH_BASE = 3'd6;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_FAULT,
    CMD_READ,
    CMD_LEAF
  } cmd_t;

  typedef struct packed {
    cmd_t        op;
    logic [63:0] value;
    logic [8:0]  index;
    logic [2:0]  level;
    logic [47:0] offset;
  } walk_cmd_t;

  function automatic logic [5:0] level_shift(input logic [2:0] level);
    logic [5:0] shift;
    case (level)
      3'd0: shift = 6'd48;
      3'd1: shift = 6'd39;
      3'd2: shift = 6'd30;
      3'd3: shift = 6'd21;
      default: shift = 6'd12;
    endcase
    return shift;
  endfunction

  function automatic logic [63:0] low_mask(input logic [2:0] level);
    return (64'd1 << level_shift(level)) - 64'd1;
  endfunction

endpackage

[rtl/s1ptw_front.sv]
// Front end of the walker: configuration registers, walk state and item classification.
// Depends on s1ptw_pkg; pushes one command per result into the command queue.
module s1ptw_front
  import s1ptw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_enable,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  logic            kind,
  input  logic [63:0]     virtual_address,
  input  logic [63:0]     descriptor,
  input  logic            queue_full,
  output logic            push,
  output walk_cmd_t       push_cmd
);

  logic        mmu_enable;
  logic [5:0]  low_region_size;
  logic [1:0]  low_region_granule;
  logic [5:0]  high_region_size;
  logic [1:0]  high_region_granule;
  logic [47:0] low_table_base;
  logic [47:0] high_table_base;

  logic        walk_busy;
  logic        walk_busy_next;
  logic [2:0]  walk_level;
  logic [2:0]  walk_level_next;
  logic [63:0] saved_address;
  logic [63:0] saved_address_next;

  logic        accept;
  logic        high_region;
  logic [5:0]  size;
  logic [1:0]  granule;
  logic [47:0] base;
  logic        start_ok;
  logic [2:0]  entry_level;
  logic [5:0]  start_shift;
  logic [6:0]  region_width;
  logic [3:0]  index_bits;
  logic [8:0]  start_index;
  logic [2:0]  next_level;
  logic [8:0]  next_index;
  logic [63:0] leaf_mask;

  assign req_stall = queue_full;
  assign accept = req_valid && !queue_full;

  always_comb begin
    high_region = virtual_address >= HIGH_REGION_BOUND;
    size = high_region ? high_region_size : low_region_size;
    granule = high_region ? high_region_granule : low_region_granule;
    base = high_region ? high_table_base : low_table_base;

    start_ok = 1'b1;
    entry_level = 3'd0;
    priority if (size >= 6'd12 && size <= 6'd15) begin
      entry_level = 3'd0;
    end else if (size >= 6'd16 && size <= 6'd24) begin
      entry_level = 3'd1;
    end else if (size >= 6'd25 && size <= 6'd33) begin
      entry_level = 3'd2;
    end else if (size >= 6'd34 && size <= 6'd42) begin
      entry_level = 3'd3;
    end else if (size >= 6'd43 && size <= 6'd48) begin
      entry_level = 3'd4;
    end else begin
      start_ok = 1'b0;
    end

    start_shift = level_shift(entry_level);
    region_width = 7'd64 - {1'b0, size};
    index_bits = 4'(region_width - {1'b0, start_shift});
    start_index = 9'(virtual_address >> start_shift) & ~(9'h1FF << index_bits);

    next_level = walk_level + 3'd1;
    next_index = 9'(saved_address >> level_shift(next_level));
    leaf_mask = low_mask(walk_level);

    walk_busy_next = walk_busy;
    walk_level_next = walk_level;
    saved_address_next = saved_address;
    push = 1'b0;
    push_cmd.op = CMD_FAULT;
    push_cmd.value = '0;
    push_cmd.index = '0;
    push_cmd.level = walk_level;
    push_cmd.offset = '0;

    if (accept) begin
      if (!kind) begin
        if (!walk_busy) begin
          push = 1'b1;
          if (!mmu_enable || (!high_region && granule == GRANULE_IDENTITY)) begin
            push_cmd.op = CMD_PASS;
            push_cmd.value = virtual_address;
          end else if (granule != GRANULE_4K || !start_ok) begin
            push_cmd.op = CMD_FAULT;
          end else begin
            walk_busy_next = 1'b1;
            walk_level_next = entry_level;
            saved_address_next = virtual_address;
            push_cmd.op = CMD_READ;
            push_cmd.value = {16'b0, base};
            push_cmd.index = start_index;
          end
        end
      end else if (walk_busy) begin
        push = 1'b1;
        if (!descriptor[0]) begin
          walk_busy_next = 1'b0;
          push_cmd.op = CMD_FAULT;
        end else if (walk_level == LAST_LEVEL || descriptor[1:0] == 2'b01) begin
          walk_busy_next = 1'b0;
          push_cmd.op = CMD_LEAF;
          push_cmd.value = descriptor;
          push_cmd.offset = saved_address[47:0] & leaf_mask[47:0];
        end else begin
          walk_level_next = next_level;
          push_cmd.op = CMD_READ;
          push_cmd.value = descriptor;
          push_cmd.index = next_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mmu_enable <= 1'b0;
      low_region_size <= '0;
      low_region_granule <= '0;
      high_region_size <= '0;
      high_region_granule <= '0;
      low_table_base <= '0;
      high_table_base <= '0;
      walk_busy <= 1'b0;
      walk_level <= '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_MMU_ENABLE: mmu_enable <= cfg_data[0];
          CFG_LOW_SIZE: low_region_size <= cfg_data[5:0];
          CFG_LOW_GRANULE: low_region_granule <= cfg_data[1:0];
          CFG_HIGH_SIZE: high_region_size <= cfg_data[5:0];
          CFG_HIGH_GRANULE: high_region_granule <= cfg_data[1:0];
          CFG_LOW_BASE: low_table_base <= cfg_data;
          CFG_HIGH_BASE: high_table_base <= cfg_data;
          default: ;
        endcase
      end
      walk_busy <= walk_busy_next;
      walk_level <= walk_level_next;
    end
  end

  always_ff @(posedge clk) begin
    saved_address <= saved_address_next;
  end

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    walk_busy |-> walk_level <= LAST_LEVEL)
    else $error("walk level beyond last level");

  a_idle_reply_dropped: assert property (@(posedge clk) disable iff (rst)
    accept && kind && !walk_busy |-> !push)
    else $error("reply while idle produced a command");

endmodule

[rtl/s1ptw_queue.sv]
// Short command queue between the front end and the back end.
// Depends on s1ptw_pkg for the command type and the queue depth.
module s1ptw_queue
  import s1ptw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  walk_cmd_t push_cmd,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output walk_cmd_t pop_cmd
);

  localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastSlot = PtrBits'(QUEUE_DEPTH - 1);

  walk_cmd_t            slots [QUEUE_DEPTH];
  logic [PtrBits-1:0]   write_ptr;
  logic [PtrBits-1:0]   read_ptr;
  logic [CountBits-1:0] count;

  assign full = count == CountBits'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign pop_cmd = slots[read_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        write_ptr <= (write_ptr == LastSlot) ? '0 : write_ptr + 1'b1;
      end
      if (pop) begin
        read_ptr <= (read_ptr == LastSlot) ? '0 : read_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[write_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty command queue");

endmodule

[rtl/s1ptw_back.sv]
// Back end of the walker: forms result addresses and holds the output register.
// Depends on s1ptw_pkg; takes commands from the command queue.
module s1ptw_back
  import s1ptw_pkg::*;
#(
  parameter int OUTPUT_ADDRESS_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        queue_empty,
  input  walk_cmd_t   cmd,
  output logic        pop,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  outcome,
  output logic [63:0] address
);

  localparam logic [63:0] OaMask = {{(64 - OUTPUT_ADDRESS_BITS){1'b0}},
                                    {OUTPUT_ADDRESS_BITS{1'b1}}};
  localparam logic [63:0] PageMask = 64'hFFF;

  logic [1:0]  outcome_next;
  logic [63:0] address_next;

  assign pop = !queue_empty && (!rsp_valid || !rsp_stall);

  always_comb begin
    unique case (cmd.op)
      CMD_PASS: begin
        outcome_next = OUT_DONE;
        address_next = cmd.value;
      end
      CMD_FAULT: begin
        outcome_next = OUT_FAULT;
        address_next = '0;
      end
      CMD_READ: begin
        outcome_next = OUT_READ;
        address_next = (cmd.value & OaMask & ~PageMask) | {52'b0, cmd.index, 3'b0};
      end
      CMD_LEAF: begin
        outcome_next = OUT_DONE;
        address_next = (cmd.value & OaMask & ~low_mask(cmd.level)) | {16'b0, cmd.offset};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome <= outcome_next;
      address <= address_next;
    end
  end

  a_fault_zero_address: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && outcome == OUT_FAULT |-> address == '0)
    else $error("fault result carries a nonzero address");

endmodule

[rtl/stage1_page_table_walker_4k.sv]
// Top level of the stage-1 table walker with a 4 KB granule.
// Depends on s1ptw_pkg and instantiates s1ptw_front, s1ptw_queue and s1ptw_back.
//
// Requests (kind 0, virtual_address) and descriptor replies (kind 1, descriptor)
// share the req channel; each transfer gives at most one result on the rsp channel.
// A result is a descriptor read request, a finished physical address or a fault.
// The caller fetches each requested descriptor and returns it as a reply.
// A request that arrives during a walk, or a reply that arrives with no walk
// in progress, is dropped without a result.
// One item is accepted per cycle while req_stall is low; its result is written
// to the command queue, then to the output register that drives rsp_valid.
// The front end updates walk state in the cycle of the transfer and
// writes a command into a two-entry queue; the back end turns it into the
// registered result.
// While rsp_stall is high the result holds, the queue fills, and req_stall
// rises once the queue is full.
// Synchronous reset clears all configuration registers, ends any walk and
// empties the queue. The user must write configuration through cfg_write_enable,
// cfg_index and cfg_data only while no item is in flight; this is not enforced.
module stage1_page_table_walker_4k
  import s1ptw_pkg::*;
#(
  parameter int OUTPUT_ADDRESS_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        kind,
  input  logic [63:0] virtual_address,
  input  logic [63:0] descriptor,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  outcome,
  output logic [63:0] address
);

  logic      push;
  walk_cmd_t push_cmd;
  logic      queue_full;
  logic      queue_empty;
  logic      pop;
  walk_cmd_t pop_cmd;

  s1ptw_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .kind             (kind),
    .virtual_address  (virtual_address),
    .descriptor       (descriptor),
    .queue_full       (queue_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  s1ptw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .empty    (queue_empty),
    .pop      (pop),
    .pop_cmd  (pop_cmd)
  );

  s1ptw_back #(
    .OUTPUT_ADDRESS_BITS (OUTPUT_ADDRESS_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .cmd         (pop_cmd),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .outcome     (outcome),
    .address     (address)
  );

endmodule
